// File: rtl/salf_pkg.sv
// ----------------------------------------------------------------------------
// salf_pkg - shared types and constants
// register codes, register widths and the sequencer states of the cache
// lookup block
// ----------------------------------------------------------------------------
package salf_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS       = 2'd2;

   // register widths and reset values
   localparam int IDX_REG_W  = 4;
   localparam int WAYS_REG_W = 4;

   localparam logic                  POLICY_LRU  = 1'b0;
   localparam logic                  POLICY_FIFO = 1'b1;
   localparam logic [IDX_REG_W-1:0]  INDEX_BITS_RESET = 4'd0;
   localparam logic [WAYS_REG_W-1:0] WAYS_RESET       = 4'd1;

   // sequencer
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

endpackage

// File: rtl/salf_req_if.sv
// ----------------------------------------------------------------------------
// salf_req_if - request channel
// one item per access: the byte address
// ----------------------------------------------------------------------------
interface salf_req_if #(
   parameter int ADDR_BITS = 24
);
   logic                 valid;
   logic                 ready;
   logic [ADDR_BITS-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

// File: rtl/salf_rsp_if.sv
// ----------------------------------------------------------------------------
// salf_rsp_if - response channel
// one item per access: hit and evicted flags
// ----------------------------------------------------------------------------
interface salf_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic evicted;

   modport source (output valid, output hit, output evicted, input ready);
   modport sink   (input valid, input hit, input evicted, output ready);
endinterface

// File: rtl/salf_csr_if.sv
// ----------------------------------------------------------------------------
// salf_csr_if - configuration write channel
// register index and write data
// ----------------------------------------------------------------------------
interface salf_csr_if;
   logic                            valid;
   logic                            ready;
   logic [salf_pkg::CSR_IDX_W-1:0]  index;
   logic [salf_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/salf_ram.sv
// ----------------------------------------------------------------------------
// salf_ram - generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module salf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/set_assoc_cache_lru_fifo_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_fifo_unit - set associative cache lookup, lru or fifo
// looks each address up in a tag store and keeps per-way age ranks
// ----------------------------------------------------------------------------
// usage
//  - req_ch: one address per item; rsp_ch: hit and evicted per request;
//    csr_ch, always ready, writes policy (0), index_bits (1), ways (2);
//    the user must write it only while idle; the block does not enforce it
//  - one compare unit walks the ways of the set, one way per cycle, from a
//    pipelined tag ram read; the set's valid bits and ranks come as one row
//    of a metadata ram and are rewritten with a single row write
//  - an item goes from accept to the next accept through the accepting
//    idle state, which issues the ram reads, the scan that compares each
//    way, and the update that loads the result register
//  - the result sits in an output register; while it is not taken the next
//    item is still accepted and scanned, and its update waits for the slot
//  - reset (synchronous, active high) returns the registers to lru,
//    index_bits 0, ways 1, then runs a clearing pass over the metadata ram,
//    one set per cycle over all 2^INDEX_BITS_MAX sets, with req_ch not ready
//  - the tag ram is never cleared; a tag is only used where its valid bit
//    is set
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_fifo_unit #(
   parameter int INDEX_BITS_MAX   = 8,
   parameter int WAYS_MAX         = 8,
   parameter int LINE_OFFSET_BITS = 3,
   parameter int ADDR_BITS        = 24
) (
   input  logic       clock,
   input  logic       reset,
   salf_req_if.sink   req_ch,
   salf_rsp_if.source rsp_ch,
   salf_csr_if.sink   csr_ch
);
   // geometry
   localparam int TAG_W     = ADDR_BITS - LINE_OFFSET_BITS;
   localparam int SET_COUNT = 1 << INDEX_BITS_MAX;
   localparam int SET_W     = (INDEX_BITS_MAX > 0) ? INDEX_BITS_MAX : 1;
   localparam int WAY_W     = (WAYS_MAX > 1) ? $clog2(WAYS_MAX) : 1;
   localparam int NW_W      = WAY_W + 1;
   localparam int AGE_W     = (WAYS_MAX > 1) ? $clog2(WAYS_MAX) : 1;
   localparam int TAG_DEPTH = SET_COUNT * WAYS_MAX;
   localparam int TAG_AW    = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;
   localparam int META_W    = WAYS_MAX * (AGE_W + 1);

   typedef struct packed {
      logic             valid;
      logic [AGE_W-1:0] age;
   } meta_type;

   typedef meta_type [WAYS_MAX-1:0] row_type;

   function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
      logic [AGE_W-1:0] r;
      r = (a < AGE_W'(WAYS_MAX - 1)) ? a + AGE_W'(1) : a;
      return r;
   endfunction

   function automatic logic [TAG_AW-1:0] tag_addr(input logic [SET_W-1:0] s,
                                                  input logic [WAY_W-1:0] w);
      logic [TAG_AW-1:0] a;
      a = TAG_AW'(s) * TAG_AW'(WAYS_MAX) + TAG_AW'(w);
      return a;
   endfunction

   // configuration registers
   logic                               policy_ff;
   logic [salf_pkg::IDX_REG_W-1:0]     index_bits_ff;
   logic [salf_pkg::WAYS_REG_W-1:0]    ways_ff;

   // sequencer and per-item state
   salf_pkg::state_type state_ff, state_in;
   logic [SET_W-1:0] clr_ff, clr_in;
   logic [SET_W-1:0] set_ff, set_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [NW_W-1:0]  nw_ff, nw_in;
   logic [WAY_W-1:0] cmp_way_ff, cmp_way_in;
   logic             hit_ff, hit_in;
   logic [WAY_W-1:0] hit_way_ff, hit_way_in;
   logic [AGE_W-1:0] hit_age_ff, hit_age_in;
   logic             free_ff, free_in;
   logic [WAY_W-1:0] free_way_ff, free_way_in;
   logic             vict_ff, vict_in;
   logic [WAY_W-1:0] vict_way_ff, vict_way_in;
   logic [AGE_W-1:0] vict_age_ff, vict_age_in;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_hit_ff, rsp_hit_in;
   logic rsp_evicted_ff, rsp_evicted_in;

   // lookup of the incoming address
   logic [salf_pkg::IDX_REG_W-1:0] ib_c;
   logic [NW_W-1:0]  nw_c;
   logic [4:0]       ways_ext;
   logic [TAG_W-1:0] line_c;
   logic [SET_W-1:0] set_mask_c;
   logic [SET_W-1:0] set_c;
   logic [TAG_W-1:0] tag_c;

   // ram ports
   logic              tag_wr_en, tag_rd_en;
   logic [TAG_AW-1:0] tag_wr_addr, tag_rd_addr;
   logic [TAG_W-1:0]  tag_rd_data;
   logic              meta_wr_en, meta_rd_en;
   logic [SET_W-1:0]  meta_wr_addr, meta_rd_addr;
   row_type           meta_wr_row, meta_rd_row;

   // shared compare unit and update
   meta_type          cur_meta;
   logic              tag_eq;
   logic [NW_W-1:0]   next_way;
   logic              last_way;
   logic              slot_free;
   logic              accept;
   logic [WAY_W-1:0]  target_way;
   logic [AGE_W-1:0]  ref_age;
   logic              inc_all;
   row_type           new_row;

   assign accept    = (state_ff == salf_pkg::ST_IDLE) && req_ch.valid;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   // ------------------------------------------------------------------
   // address split with the current geometry
   // ------------------------------------------------------------------
   always_comb begin
      ib_c = (index_bits_ff > salf_pkg::IDX_REG_W'(INDEX_BITS_MAX))
           ? salf_pkg::IDX_REG_W'(INDEX_BITS_MAX) : index_bits_ff;
      ways_ext = {1'b0, ways_ff};
      if (ways_ext == 5'd0) begin
         nw_c = NW_W'(1);
      end else if (ways_ext > 5'(WAYS_MAX)) begin
         nw_c = NW_W'(WAYS_MAX);
      end else begin
         nw_c = NW_W'(ways_ext);
      end
      line_c     = req_ch.address[ADDR_BITS-1:LINE_OFFSET_BITS];
      set_mask_c = ~({SET_W{1'b1}} << ib_c);
      set_c      = SET_W'(line_c) & set_mask_c;
      tag_c      = line_c >> ib_c;
   end

   // ------------------------------------------------------------------
   // compare unit: one way per cycle
   // ------------------------------------------------------------------
   always_comb begin
      cur_meta = meta_rd_row[cmp_way_ff];
      tag_eq   = (tag_rd_data == tag_ff);
      next_way = NW_W'(cmp_way_ff) + NW_W'(1);
      last_way = (next_way >= nw_ff);
   end

   // ------------------------------------------------------------------
   // new metadata row for the set
   // ------------------------------------------------------------------
   always_comb begin
      target_way = hit_ff ? hit_way_ff : (free_ff ? free_way_ff : vict_way_ff);
      ref_age    = hit_ff ? hit_age_ff : vict_age_ff;
      inc_all    = !hit_ff && free_ff;
      new_row    = meta_rd_row;
      for (int w = 0; w < WAYS_MAX; w++) begin
         if (NW_W'(w) < nw_ff) begin
            if (WAY_W'(w) == target_way) begin
               new_row[w].valid = 1'b1;
               new_row[w].age   = '0;
            end else if (meta_rd_row[w].valid &&
                         (inc_all || (meta_rd_row[w].age < ref_age))) begin
               new_row[w].age = age_inc(meta_rd_row[w].age);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         salf_pkg::ST_CLEAR: begin
            if (clr_ff == SET_W'(SET_COUNT - 1)) begin
               state_in = salf_pkg::ST_IDLE;
            end
         end
         salf_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = salf_pkg::ST_SCAN;
            end
         end
         salf_pkg::ST_SCAN: begin
            if (last_way) begin
               state_in = salf_pkg::ST_UPDATE;
            end
         end
         salf_pkg::ST_UPDATE: begin
            if (slot_free) begin
               state_in = salf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = salf_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // outputs: handshakes and ram controls
   // ------------------------------------------------------------------
   always_comb begin
      req_ch.ready = 1'b0;
      tag_rd_en    = 1'b0;
      tag_rd_addr  = tag_addr(set_ff, WAY_W'(next_way));
      tag_wr_en    = 1'b0;
      tag_wr_addr  = tag_addr(set_ff, target_way);
      meta_rd_en   = 1'b0;
      meta_rd_addr = set_c;
      meta_wr_en   = 1'b0;
      meta_wr_addr = set_ff;
      meta_wr_row  = new_row;
      case (state_ff)
         salf_pkg::ST_CLEAR: begin
            meta_wr_en   = 1'b1;
            meta_wr_addr = clr_ff;
            meta_wr_row  = '0;
         end
         salf_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            // first tag read and the set's row go out with the accept
            tag_rd_en    = req_ch.valid;
            tag_rd_addr  = tag_addr(set_c, '0);
            meta_rd_en   = req_ch.valid;
         end
         salf_pkg::ST_SCAN: begin
            tag_rd_en = !last_way;
         end
         salf_pkg::ST_UPDATE: begin
            // fifo hits leave the ranks alone
            meta_wr_en = slot_free && !(hit_ff && (policy_ff == salf_pkg::POLICY_FIFO));
            tag_wr_en  = slot_free && !hit_ff;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   assign csr_ch.ready   = 1'b1;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.hit     = rsp_hit_ff;
   assign rsp_ch.evicted = rsp_evicted_ff;

   // ------------------------------------------------------------------
   // datapath next values
   // ------------------------------------------------------------------
   always_comb begin
      clr_in         = clr_ff;
      set_in         = set_ff;
      tag_in         = tag_ff;
      nw_in          = nw_ff;
      cmp_way_in     = cmp_way_ff;
      hit_in         = hit_ff;
      hit_way_in     = hit_way_ff;
      hit_age_in     = hit_age_ff;
      free_in        = free_ff;
      free_way_in    = free_way_ff;
      vict_in        = vict_ff;
      vict_way_in    = vict_way_ff;
      vict_age_in    = vict_age_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_evicted_in = rsp_evicted_ff;

      if (state_ff == salf_pkg::ST_CLEAR) begin
         clr_in = clr_ff + SET_W'(1);
      end

      if (accept) begin
         set_in     = set_c;
         tag_in     = tag_c;
         nw_in      = nw_c;
         cmp_way_in = '0;
         hit_in     = 1'b0;
         free_in    = 1'b0;
         vict_in    = 1'b0;
      end

      if (state_ff == salf_pkg::ST_SCAN) begin
         if (cur_meta.valid) begin
            // lowest matching way wins
            if (!hit_ff && tag_eq) begin
               hit_in     = 1'b1;
               hit_way_in = cmp_way_ff;
               hit_age_in = cur_meta.age;
            end
            // oldest valid way, lowest way on a tie
            if (!vict_ff || (cur_meta.age > vict_age_ff)) begin
               vict_in     = 1'b1;
               vict_way_in = cmp_way_ff;
               vict_age_in = cur_meta.age;
            end
         end else if (!free_ff) begin
            free_in     = 1'b1;
            free_way_in = cmp_way_ff;
         end
         if (!last_way) begin
            cmp_way_in = WAY_W'(next_way);
         end
      end

      if ((state_ff == salf_pkg::ST_UPDATE) && slot_free) begin
         rsp_valid_in   = 1'b1;
         rsp_hit_in     = hit_ff;
         rsp_evicted_in = !hit_ff && !free_ff;
      end
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= salf_pkg::ST_CLEAR;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         policy_ff     <= salf_pkg::POLICY_LRU;
         index_bits_ff <= salf_pkg::INDEX_BITS_RESET;
         ways_ff       <= salf_pkg::WAYS_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid) begin
            case (csr_ch.index)
               salf_pkg::CSR_POLICY:     policy_ff     <= csr_ch.data[0];
               salf_pkg::CSR_INDEX_BITS: index_bits_ff <= csr_ch.data;
               salf_pkg::CSR_WAYS:       ways_ff       <= csr_ch.data;
               default:                  ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      set_ff         <= set_in;
      tag_ff         <= tag_in;
      nw_ff          <= nw_in;
      cmp_way_ff     <= cmp_way_in;
      hit_ff         <= hit_in;
      hit_way_ff     <= hit_way_in;
      hit_age_ff     <= hit_age_in;
      free_ff        <= free_in;
      free_way_ff    <= free_way_in;
      vict_ff        <= vict_in;
      vict_way_ff    <= vict_way_in;
      vict_age_ff    <= vict_age_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_evicted_ff <= rsp_evicted_in;
   end

   // ------------------------------------------------------------------
   // stores
   // ------------------------------------------------------------------
   salf_ram #(
      .WIDTH (TAG_W),
      .DEPTH (TAG_DEPTH)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (tag_wr_addr),
      .wr_data (tag_ff),
      .rd_en   (tag_rd_en),
      .rd_addr (tag_rd_addr),
      .rd_data (tag_rd_data)
   );

   // one row per set: valid bit and age rank of every way
   salf_ram #(
      .WIDTH (META_W),
      .DEPTH (SET_COUNT)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (meta_wr_addr),
      .wr_data (meta_wr_row),
      .rd_en   (meta_rd_en),
      .rd_addr (meta_rd_addr),
      .rd_data (meta_rd_row)
   );

endmodule
